// File: src/euler_fly_camera_update_assert.svh
// Assertion macros for the camera update block.
// Included by the top level; no other dependencies.
`ifndef EULER_FLY_CAMERA_UPDATE_ASSERT_SVH
`define EULER_FLY_CAMERA_UPDATE_ASSERT_SVH

// same-cycle implication
`define EFC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/efc_pkg.sv
// Shared types, constants and tables for the camera update block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package efc_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_DEPTH   = 24;
   localparam int STEP_W       = $clog2(ATAN_DEPTH);

   localparam int UNIT         = 16384;
   localparam int HALF_TURN    = 23040;
   localparam int FULL_TURN    = 46080;
   localparam int QUARTER_TURN = 11520;
   localparam int PITCH_LIMIT  = 11392;
   localparam int TP_PITCH     = -3200;
   localparam int TP_LIFT      = 262144;
   localparam int FP_LIFT      = 111411;
   localparam int FP_SCALE     = 52429;

   localparam int VEC_W  = 33;
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int SQ_W   = 64;
   localparam int LEN_W  = 32;
   localparam int MAG_W  = 32;
   localparam int REM_W  = 47;
   localparam int QUO_W  = 15;
   localparam int ANG_W  = 21;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_X  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_Y  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_Z  = 3'd4;

   localparam logic [1:0] KIND_MOVE  = 2'd0;
   localparam logic [1:0] KIND_MOUSE = 2'd1;
   localparam logic [1:0] KIND_THIRD = 2'd2;
   localparam logic [1:0] KIND_FIRST = 2'd3;

   localparam logic [2:0] DIR_FWD   = 3'd0;
   localparam logic [2:0] DIR_BACK  = 3'd1;
   localparam logic [2:0] DIR_LEFT  = 3'd2;
   localparam logic [2:0] DIR_RIGHT = 3'd3;
   localparam logic [2:0] DIR_UP    = 3'd4;
   localparam logic [2:0] DIR_DOWN  = 3'd5;

   localparam logic [1:0] DST_FRONT = 2'd0;
   localparam logic [1:0] DST_RIGHT = 2'd1;
   localparam logic [1:0] DST_UP    = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         move_dir;
      logic [15:0]        delta_time;
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
      logic               clamp_pitch;
      logic signed [31:0] target_pos_x;
      logic signed [31:0] target_pos_y;
      logic signed [31:0] target_pos_z;
      logic signed [15:0] target_dir_x;
      logic signed [15:0] target_dir_y;
      logic signed [15:0] target_dir_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] cam_pos_x;
      logic signed [31:0] cam_pos_y;
      logic signed [31:0] cam_pos_z;
      logic signed [15:0] front_x;
      logic signed [15:0] front_y;
      logic signed [15:0] front_z;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic signed [15:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic               done;
      logic signed [15:0] sin_val;
      logic signed [15:0] cos_val;
   } cordic_rsp_type;

   typedef struct packed {
      logic                    start;
      logic signed [VEC_W-1:0] v0;
      logic signed [VEC_W-1:0] v1;
      logic signed [VEC_W-1:0] v2;
      logic [SQ_W-1:0]         sq;
   } norm_req_type;

   typedef struct packed {
      logic               done;
      logic signed [15:0] c0;
      logic signed [15:0] c1;
      logic signed [15:0] c2;
   } norm_rsp_type;

   typedef enum logic [1:0] {NP_IDLE, NP_SQRT, NP_LOAD, NP_DIV} norm_phase_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MV_SPD, ST_MV_SPDW, ST_MV_MUL, ST_MV_ACC,
      ST_MS_YAW, ST_MS_YAWW, ST_MS_PIT, ST_MS_PITW, ST_MS_WRAP,
      ST_TP, ST_FP_MUL, ST_FP_ACC,
      ST_FR_CY, ST_FR_CYW, ST_FR_CP, ST_FR_CPW, ST_FR_M0, ST_FR_M1, ST_FR_M2,
      ST_CR_MUL, ST_CR_ACC, ST_NM_SQ, ST_NM_SA, ST_NM_RUN, ST_NM_WAIT, ST_FIN
   } state_type;

   // arctangent of 2^-i in 2^-22 degree
   function automatic logic signed [31:0] atan_entry(input logic [STEP_W-1:0] i);
      logic signed [31:0] r;
      case (i)
         5'd0:    r = 32'sd188743680;
         5'd1:    r = 32'sd111421900;
         5'd2:    r = 32'sd58872272;
         5'd3:    r = 32'sd29884485;
         5'd4:    r = 32'sd15000234;
         5'd5:    r = 32'sd7507429;
         5'd6:    r = 32'sd3754631;
         5'd7:    r = 32'sd1877430;
         5'd8:    r = 32'sd938729;
         5'd9:    r = 32'sd469366;
         5'd10:   r = 32'sd234683;
         5'd11:   r = 32'sd117342;
         5'd12:   r = 32'sd58671;
         5'd13:   r = 32'sd29335;
         5'd14:   r = 32'sd14668;
         5'd15:   r = 32'sd7334;
         5'd16:   r = 32'sd3667;
         5'd17:   r = 32'sd1833;
         5'd18:   r = 32'sd917;
         5'd19:   r = 32'sd458;
         5'd20:   r = 32'sd229;
         5'd21:   r = 32'sd115;
         5'd22:   r = 32'sd57;
         5'd23:   r = 32'sd29;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

endpackage

// File: src/euler_fly_camera_update.sv
// Euler-angle fly camera: keeps position, yaw, pitch and front/right/up vectors and
// returns the full camera state after each transaction. One transaction at a time; a
// move is the shortest and a mouse or first-person transaction the longest, set mainly
// by the shared normaliser (a 32-step square root and three 15-step divides per vector,
// three vectors), the 16-step CORDIC run twice, and the single shared 33x33
// multiplier.
`timescale 1ns / 1ps
`include "euler_fly_camera_update_assert.svh"

module euler_fly_camera_update (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  efc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output efc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic [efc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [efc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import efc_pkg::*;

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] idx_ff, idx_in;
   logic [1:0] dst_ff, dst_in;

   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [15:0] front_ff [3];
   logic signed [15:0] front_in [3];
   logic signed [15:0] right_ff [3];
   logic signed [15:0] right_in [3];
   logic signed [15:0] up_ff [3];
   logic signed [15:0] up_in [3];
   logic signed [15:0] wup_ff [3];
   logic signed [15:0] wup_in [3];
   logic signed [15:0] yaw_ff, yaw_in, pitch_ff, pitch_in;
   logic [15:0] speed_ff, speed_in, sens_ff, sens_in;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic [31:0] spd_ff, spd_in;
   logic signed [ANG_W-1:0] dyaw_ff, dyaw_in, ang_y_ff, ang_y_in, ang_p_ff, ang_p_in;
   logic signed [15:0] sy_ff, sy_in, cy_ff, cy_in, sp_ff, sp_in, cp_ff, cp_in;
   logic signed [VEC_W-1:0] vec_ff [3];
   logic signed [VEC_W-1:0] vec_in [3];
   logic [SQ_W-1:0] sq_ff, sq_in;

   logic signed [15:0] mv_vec [3];
   logic signed [15:0] ca [3];
   logic signed [15:0] cb [3];
   logic signed [31:0] tp [3];
   logic signed [15:0] td [3];
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [35:0] step_v, sum_v;
   logic mv_neg, mv_valid;

   cordic_req_type cordic_req;
   cordic_rsp_type cordic_rsp;
   norm_req_type   norm_req;
   norm_rsp_type   norm_rsp;

   efc_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cordic_req),
      .rsp   (cordic_rsp)
   );

   efc_norm u_norm (
      .clock (clock),
      .reset (reset),
      .req   (norm_req),
      .rsp   (norm_rsp)
   );

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) r = 32'sh7fffffff;
      else if (v < -36'sd2147483648) r = 32'sh80000000;
      else r = 32'(v);
      return r;
   endfunction

   assign tp[0] = req_ff.target_pos_x;
   assign tp[1] = req_ff.target_pos_y;
   assign tp[2] = req_ff.target_pos_z;
   assign td[0] = req_ff.target_dir_x;
   assign td[1] = req_ff.target_dir_y;
   assign td[2] = req_ff.target_dir_z;

   always_comb begin
      mv_vec   = wup_ff;
      mv_neg   = 1'b0;
      mv_valid = 1'b1;
      unique case (req_ff.move_dir)
         DIR_FWD:   mv_vec = front_ff;
         DIR_BACK:  begin mv_vec = front_ff; mv_neg = 1'b1; end
         DIR_LEFT:  begin mv_vec = right_ff; mv_neg = 1'b1; end
         DIR_RIGHT: mv_vec = right_ff;
         DIR_UP:    mv_vec = wup_ff;
         DIR_DOWN:  begin mv_vec = wup_ff; mv_neg = 1'b1; end
         default:   mv_valid = 1'b0;
      endcase
      if (dst_ff == DST_UP) begin
         ca = right_ff;
         cb = front_ff;
      end else begin
         ca = front_ff;
         cb = wup_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      idx_in       = idx_ff;
      dst_in       = dst_ff;
      pos_in       = pos_ff;
      front_in     = front_ff;
      right_in     = right_ff;
      up_in        = up_ff;
      wup_in       = wup_ff;
      yaw_in       = yaw_ff;
      pitch_in     = pitch_ff;
      speed_in     = speed_ff;
      sens_in      = sens_ff;
      spd_in       = spd_ff;
      dyaw_in      = dyaw_ff;
      ang_y_in     = ang_y_ff;
      ang_p_in     = ang_p_ff;
      sy_in        = sy_ff;
      cy_in        = cy_ff;
      sp_in        = sp_ff;
      cp_in        = cp_ff;
      vec_in       = vec_ff;
      sq_in        = sq_ff;
      mul_a        = '0;
      mul_b        = '0;
      prod_rnd     = '0;
      step_v       = '0;
      sum_v        = '0;
      cordic_req   = '0;
      norm_req.start = 1'b0;
      norm_req.v0    = vec_ff[0];
      norm_req.v1    = vec_ff[1];
      norm_req.v2    = vec_ff[2];
      norm_req.sq    = sq_ff;
      req_ready      = (state_ff == ST_IDLE);

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SPEED: speed_in  = csr_wdata;
            CSR_SENS:  sens_in   = csr_wdata;
            CSR_UP_X:  wup_in[0] = $signed(csr_wdata);
            CSR_UP_Y:  wup_in[1] = $signed(csr_wdata);
            CSR_UP_Z:  wup_in[2] = $signed(csr_wdata);
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               idx_in = '0;
               unique case (req_data.kind)
                  KIND_MOVE:  state_in = ST_MV_SPD;
                  KIND_MOUSE: state_in = ST_MS_YAW;
                  KIND_THIRD: state_in = ST_TP;
                  KIND_FIRST: state_in = ST_FP_MUL;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_MV_SPD: begin
            mul_a    = $signed({17'd0, speed_ff});
            mul_b    = $signed({17'd0, req_ff.delta_time});
            state_in = ST_MV_SPDW;
         end
         ST_MV_SPDW: begin
            spd_in   = 32'(prod_ff);
            state_in = mv_valid ? ST_MV_MUL : ST_FIN;
         end
         ST_MV_MUL: begin
            mul_a    = $signed({1'b0, spd_ff});
            mul_b    = MUL_W'(mv_vec[idx_ff[1:0]]);
            state_in = ST_MV_ACC;
         end
         ST_MV_ACC: begin
            prod_rnd = prod_ff + PROD_W'(64'sd2097152);
            step_v   = 36'(prod_rnd >>> 22);
            sum_v    = mv_neg ? 36'(pos_ff[idx_ff[1:0]]) - step_v
                              : 36'(pos_ff[idx_ff[1:0]]) + step_v;
            pos_in[idx_ff[1:0]] = sat32(sum_v);
            idx_in   = idx_ff + 1'b1;
            state_in = (idx_ff == 3'd2) ? ST_FIN : ST_MV_MUL;
         end
         ST_MS_YAW: begin
            mul_a    = MUL_W'(req_ff.offset_x);
            mul_b    = $signed({17'd0, sens_ff});
            state_in = ST_MS_YAWW;
         end
         ST_MS_YAWW: begin
            prod_rnd = prod_ff + PROD_W'(64'sd4096);
            dyaw_in  = ANG_W'(prod_rnd >>> 13);
            state_in = ST_MS_PIT;
         end
         ST_MS_PIT: begin
            mul_a    = MUL_W'(req_ff.offset_y);
            mul_b    = $signed({17'd0, sens_ff});
            state_in = ST_MS_PITW;
         end
         ST_MS_PITW: begin
            prod_rnd = prod_ff + PROD_W'(64'sd4096);
            ang_y_in = ANG_W'(yaw_ff) + dyaw_ff;
            ang_p_in = ANG_W'(pitch_ff) + ANG_W'(prod_rnd >>> 13);
            if (req_ff.clamp_pitch) begin
               if (ang_p_in > ANG_W'(PITCH_LIMIT)) ang_p_in = ANG_W'(PITCH_LIMIT);
               else if (ang_p_in < -ANG_W'(PITCH_LIMIT)) ang_p_in = -ANG_W'(PITCH_LIMIT);
            end
            state_in = ST_MS_WRAP;
         end
         ST_MS_WRAP: begin
            // one turn per cycle until both land in (-180, 180]
            if (ang_y_ff > ANG_W'(HALF_TURN)) ang_y_in = ang_y_ff - ANG_W'(FULL_TURN);
            else if (ang_y_ff <= -ANG_W'(HALF_TURN)) ang_y_in = ang_y_ff + ANG_W'(FULL_TURN);
            if (ang_p_ff > ANG_W'(HALF_TURN)) ang_p_in = ang_p_ff - ANG_W'(FULL_TURN);
            else if (ang_p_ff <= -ANG_W'(HALF_TURN)) ang_p_in = ang_p_ff + ANG_W'(FULL_TURN);
            if (ang_y_in == ang_y_ff && ang_p_in == ang_p_ff) begin
               yaw_in   = 16'(ang_y_ff);
               pitch_in = 16'(ang_p_ff);
               state_in = ST_FR_CY;
            end
         end
         ST_TP: begin
            for (int i = 0; i < 3; i++) begin
               pos_in[i]   = sat32(36'(tp[i]) - (36'(td[i]) <<< 5)
                                   + ((i == 1) ? 36'(TP_LIFT) : 36'sd0));
               front_in[i] = td[i];
            end
            pitch_in = 16'(TP_PITCH);
            dst_in   = DST_RIGHT;
            idx_in   = '0;
            state_in = ST_CR_MUL;
         end
         ST_FP_MUL: begin
            mul_a    = MUL_W'(td[idx_ff[1:0]]);
            mul_b    = MUL_W'(FP_SCALE);
            state_in = ST_FP_ACC;
         end
         ST_FP_ACC: begin
            prod_rnd = prod_ff + PROD_W'(64'sd8192);
            step_v   = 36'(prod_rnd >>> 14);
            sum_v    = 36'(tp[idx_ff[1:0]]) + step_v
                       + ((idx_ff == 3'd1) ? 36'(FP_LIFT) : 36'sd0);
            pos_in[idx_ff[1:0]] = sat32(sum_v);
            idx_in   = idx_ff + 1'b1;
            state_in = (idx_ff == 3'd2) ? ST_FR_CY : ST_FP_MUL;
         end
         ST_FR_CY: begin
            cordic_req.start = 1'b1;
            cordic_req.angle = yaw_ff;
            state_in         = ST_FR_CYW;
         end
         ST_FR_CYW: begin
            if (cordic_rsp.done) begin
               sy_in    = cordic_rsp.sin_val;
               cy_in    = cordic_rsp.cos_val;
               state_in = ST_FR_CP;
            end
         end
         ST_FR_CP: begin
            cordic_req.start = 1'b1;
            cordic_req.angle = pitch_ff;
            state_in         = ST_FR_CPW;
         end
         ST_FR_CPW: begin
            if (cordic_rsp.done) begin
               sp_in    = cordic_rsp.sin_val;
               cp_in    = cordic_rsp.cos_val;
               state_in = ST_FR_M0;
            end
         end
         ST_FR_M0: begin
            mul_a    = MUL_W'(cy_ff);
            mul_b    = MUL_W'(cp_ff);
            state_in = ST_FR_M1;
         end
         ST_FR_M1: begin
            vec_in[0] = VEC_W'(prod_ff);
            mul_a     = MUL_W'(sy_ff);
            mul_b     = MUL_W'(cp_ff);
            state_in  = ST_FR_M2;
         end
         ST_FR_M2: begin
            vec_in[2] = VEC_W'(prod_ff);
            vec_in[1] = VEC_W'(sp_ff) <<< 14;
            dst_in    = DST_FRONT;
            idx_in    = '0;
            state_in  = ST_NM_SQ;
         end
         ST_CR_MUL: begin
            unique case (idx_ff)
               3'd0:    begin mul_a = MUL_W'(ca[1]); mul_b = MUL_W'(cb[2]); end
               3'd1:    begin mul_a = MUL_W'(ca[2]); mul_b = MUL_W'(cb[1]); end
               3'd2:    begin mul_a = MUL_W'(ca[2]); mul_b = MUL_W'(cb[0]); end
               3'd3:    begin mul_a = MUL_W'(ca[0]); mul_b = MUL_W'(cb[2]); end
               3'd4:    begin mul_a = MUL_W'(ca[0]); mul_b = MUL_W'(cb[1]); end
               3'd5:    begin mul_a = MUL_W'(ca[1]); mul_b = MUL_W'(cb[0]); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
            state_in = ST_CR_ACC;
         end
         ST_CR_ACC: begin
            if (!idx_ff[0]) vec_in[idx_ff[2:1]] = VEC_W'(prod_ff);
            else vec_in[idx_ff[2:1]] = vec_ff[idx_ff[2:1]] - VEC_W'(prod_ff);
            if (idx_ff == 3'd5) begin
               idx_in   = '0;
               state_in = ST_NM_SQ;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_CR_MUL;
            end
         end
         ST_NM_SQ: begin
            mul_a    = vec_ff[idx_ff[1:0]];
            mul_b    = vec_ff[idx_ff[1:0]];
            state_in = ST_NM_SA;
         end
         ST_NM_SA: begin
            sq_in    = ((idx_ff == 3'd0) ? '0 : sq_ff) + SQ_W'(prod_ff);
            idx_in   = idx_ff + 1'b1;
            state_in = (idx_ff == 3'd2) ? ST_NM_RUN : ST_NM_SQ;
         end
         ST_NM_RUN: begin
            norm_req.start = 1'b1;
            state_in       = ST_NM_WAIT;
         end
         ST_NM_WAIT: begin
            if (norm_rsp.done) begin
               idx_in = '0;
               unique case (dst_ff)
                  DST_FRONT: begin
                     front_in[0] = norm_rsp.c0;
                     front_in[1] = norm_rsp.c1;
                     front_in[2] = norm_rsp.c2;
                     dst_in      = DST_RIGHT;
                     state_in    = ST_CR_MUL;
                  end
                  DST_RIGHT: begin
                     right_in[0] = norm_rsp.c0;
                     right_in[1] = norm_rsp.c1;
                     right_in[2] = norm_rsp.c2;
                     dst_in      = DST_UP;
                     state_in    = ST_CR_MUL;
                  end
                  default: begin
                     up_in[0] = norm_rsp.c0;
                     up_in[1] = norm_rsp.c1;
                     up_in[2] = norm_rsp.c2;
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.cam_pos_x = pos_ff[0];
               rsp_in.cam_pos_y = pos_ff[1];
               rsp_in.cam_pos_z = pos_ff[2];
               rsp_in.front_x   = front_ff[0];
               rsp_in.front_y   = front_ff[1];
               rsp_in.front_z   = front_ff[2];
               rsp_in.right_x   = right_ff[0];
               rsp_in.right_y   = right_ff[1];
               rsp_in.right_z   = right_ff[2];
               rsp_in.up_x      = up_ff[0];
               rsp_in.up_y      = up_ff[1];
               rsp_in.up_z      = up_ff[2];
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '{32'sd0, 32'sd0, 32'sd0};
         front_ff     <= '{16'sd0, 16'sd0, -16'sd16384};
         right_ff     <= '{16'sd16384, 16'sd0, 16'sd0};
         up_ff        <= '{16'sd0, 16'sd16384, 16'sd0};
         wup_ff       <= '{16'sd0, 16'sd16384, 16'sd0};
         yaw_ff       <= -16'sd11520;
         pitch_ff     <= 16'sd0;
         speed_ff     <= 16'd640;
         sens_ff      <= 16'd6554;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         front_ff     <= front_in;
         right_ff     <= right_in;
         up_ff        <= up_in;
         wup_ff       <= wup_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         speed_ff     <= speed_in;
         sens_ff      <= sens_in;
      end
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      idx_ff   <= idx_in;
      dst_ff   <= dst_in;
      prod_ff  <= mul_a * mul_b;
      spd_ff   <= spd_in;
      dyaw_ff  <= dyaw_in;
      ang_y_ff <= ang_y_in;
      ang_p_ff <= ang_p_in;
      sy_ff    <= sy_in;
      cy_ff    <= cy_in;
      sp_ff    <= sp_in;
      cp_ff    <= cp_in;
      vec_ff   <= vec_in;
      sq_ff    <= sq_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `EFC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "accepted transaction did not leave idle")
   `EFC_ASSERT_SAME(a_norm_done_in_wait, clock, reset, norm_rsp.done, state_ff == ST_NM_WAIT, "normaliser finished outside its wait state")
   `EFC_ASSERT_SAME(a_cordic_done_in_wait, clock, reset, cordic_rsp.done, state_ff == ST_FR_CYW || state_ff == ST_FR_CPW, "CORDIC finished outside its wait states")
   `EFC_ASSERT_NEXT(a_fin_loads_result, clock, reset, state_ff == ST_FIN && !rsp_valid_ff, rsp_valid_ff && state_ff == ST_IDLE, "free result register not loaded")

endmodule

// File: src/efc_cordic.sv
// Iterative CORDIC sine and cosine, one rotation per cycle.
// Depends on efc_pkg.
`timescale 1ns / 1ps

module efc_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  efc_pkg::cordic_req_type req,
   output efc_pkg::cordic_rsp_type rsp
);
   import efc_pkg::*;

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic neg_ff, neg_in;
   logic signed [15:0] sin_ff, sin_in, cos_ff, cos_in;
   logic signed [16:0] ang_ext, ang_red;
   logic neg_red;
   logic signed [33:0] dx, dy, atan_v;

   function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
      logic signed [34:0] t;
      logic signed [18:0] r;
      t = 35'(v) + 35'sd32768;
      r = 19'(t >>> 16);
      if (r > 19'sd16384) r = 19'sd16384;
      else if (r < -19'sd16384) r = -19'sd16384;
      return 16'(r);
   endfunction

   always_comb begin
      ang_ext = 17'(req.angle);
      ang_red = ang_ext;
      neg_red = 1'b0;
      if (ang_ext > 17'(QUARTER_TURN)) begin
         ang_red = ang_ext - 17'(HALF_TURN);
         neg_red = 1'b1;
      end else if (ang_ext < -17'(QUARTER_TURN)) begin
         ang_red = ang_ext + 17'(HALF_TURN);
         neg_red = 1'b1;
      end

      dx     = y_ff >>> step_ff;
      dy     = x_ff >>> step_ff;
      atan_v = 34'(atan_entry(step_ff));

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      neg_in  = neg_ff;
      sin_in  = sin_ff;
      cos_in  = cos_ff;

      if (!busy_ff) begin
         if (req.start) begin
            busy_in = 1'b1;
            step_in = '0;
            x_in    = CORDIC_GAIN;
            y_in    = '0;
            z_in    = {{2{ang_red[16]}}, ang_red, 15'd0};
            neg_in  = neg_red;
         end
      end else begin
         if (z_ff >= 34'sd0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_v;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            cos_in  = to_q14(neg_ff ? -x_in : x_in);
            sin_in  = to_q14(neg_ff ? -y_in : y_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      neg_ff  <= neg_in;
      sin_ff  <= sin_in;
      cos_ff  <= cos_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.sin_val = sin_ff;
   assign rsp.cos_val = cos_ff;

endmodule

// File: src/efc_norm.sv
// Vector normaliser: bit-pair square root, then one restoring divide per component.
// Depends on efc_pkg.
`timescale 1ns / 1ps

module efc_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  efc_pkg::norm_req_type req,
   output efc_pkg::norm_rsp_type rsp
);
   import efc_pkg::*;

   norm_phase_type phase_ff, phase_in;
   logic done_ff, done_in;
   logic [SQ_W-1:0] n_ff, n_in, r_ff, r_in, b_ff, b_in, trial_sq;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [1:0] ci_ff, ci_in;
   logic [3:0] kk_ff, kk_in;
   logic [REM_W-1:0] rem_ff, rem_in, trial_div;
   logic [QUO_W-1:0] q_ff, q_in, q_cap;
   logic [MAG_W-1:0] mag_ff [3];
   logic [MAG_W-1:0] mag_in [3];
   logic neg_ff [3];
   logic neg_in [3];
   logic signed [15:0] res_ff [3];
   logic signed [15:0] res_in [3];
   logic signed [VEC_W-1:0] v_src [3];

   assign v_src[0] = req.v0;
   assign v_src[1] = req.v1;
   assign v_src[2] = req.v2;

   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      n_in     = n_ff;
      r_in     = r_ff;
      b_in     = b_ff;
      len_in   = len_ff;
      ci_in    = ci_ff;
      kk_in    = kk_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      res_in   = res_ff;
      trial_sq  = r_ff + b_ff;
      trial_div = REM_W'(len_ff) << kk_ff;
      q_cap     = '0;

      unique case (phase_ff)
         NP_IDLE: begin
            if (req.start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = v_src[i][VEC_W-1];
                  mag_in[i] = MAG_W'(v_src[i][VEC_W-1] ? -v_src[i] : v_src[i]);
               end
               n_in     = req.sq;
               r_in     = '0;
               b_in     = SQ_W'(1) << (SQ_W - 2);
               phase_in = NP_SQRT;
            end
         end
         NP_SQRT: begin
            if (n_ff >= trial_sq) begin
               n_in = n_ff - trial_sq;
               r_in = (r_ff >> 1) + b_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            b_in = b_ff >> 2;
            if (b_ff[0]) begin
               len_in   = LEN_W'(r_in);
               ci_in    = 2'd0;
               phase_in = NP_LOAD;
            end
         end
         NP_LOAD: begin
            rem_in   = (REM_W'(mag_ff[ci_ff]) << 14) + REM_W'(len_ff >> 1);
            q_in     = '0;
            kk_in    = 4'd14;
            phase_in = NP_DIV;
         end
         NP_DIV: begin
            if (rem_ff >= trial_div) begin
               rem_in = rem_ff - trial_div;
               q_in   = q_ff | (QUO_W'(1) << kk_ff);
            end
            kk_in = kk_ff - 1'b1;
            if (kk_ff == 4'd0) begin
               q_cap = (q_in > QUO_W'(UNIT)) ? QUO_W'(UNIT) : q_in;
               if (len_ff == '0) begin
                  res_in[ci_ff] = '0;
               end else if (neg_ff[ci_ff]) begin
                  res_in[ci_ff] = -$signed({1'b0, q_cap});
               end else begin
                  res_in[ci_ff] = $signed({1'b0, q_cap});
               end
               ci_in = ci_ff + 1'b1;
               if (ci_ff == 2'd2) begin
                  done_in  = 1'b1;
                  phase_in = NP_IDLE;
               end else begin
                  phase_in = NP_LOAD;
               end
            end
         end
         default: phase_in = NP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= NP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      n_ff   <= n_in;
      r_ff   <= r_in;
      b_ff   <= b_in;
      len_ff <= len_in;
      ci_ff  <= ci_in;
      kk_ff  <= kk_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.c0   = res_ff[0];
   assign rsp.c1   = res_ff[1];
   assign rsp.c2   = res_ff[2];

endmodule

// File: dv/tb.sv
// Self-checking testbench for euler_fly_camera_update: predicts the camera state after
// each transaction and compares every response field. Depends on efc_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import efc_pkg::*;

   class camera_scoreboard;
      logic signed [31:0] pos [3];
      logic signed [15:0] fv [3], rv [3], uv [3], wup [3];
      logic signed [15:0] yaw, pitch;
      logic [15:0] speed, sens;
      rsp_type pending [$];
      int errors, checked;

      function new();
         pos = '{0, 0, 0};
         fv = '{16'sd0, 16'sd0, -16'sd16384};
         rv = '{16'sd16384, 16'sd0, 16'sd0};
         uv = '{16'sd0, 16'sd16384, 16'sd0};
         wup = '{16'sd0, 16'sd16384, 16'sd0};
         yaw = -16'sd11520;
         pitch = 0;
         speed = 640;
         sens = 6554;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
         case (idx)
            CSR_SPEED: speed = val;
            CSR_SENS:  sens = val;
            CSR_UP_X:  wup[0] = val;
            CSR_UP_Y:  wup[1] = val;
            CSR_UP_Z:  wup[2] = val;
            default: ;
         endcase
      endfunction

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function logic signed [15:0] wrap_deg(longint v);
         longint r;
         r = v % FULL_TURN;
         if (r < 0) r += FULL_TURN;
         if (r > HALF_TURN) r -= FULL_TURN;
         return 16'(r);
      endfunction

      function longint q14(longint v);
         longint r;
         r = (v + 32768) >>> 16;
         if (r > UNIT) r = UNIT;
         if (r < -UNIT) r = -UNIT;
         return r;
      endfunction

      function void sin_cos(longint a, output longint s, output longint c);
         longint x, y, z, dx, dy;
         bit flip;
         flip = 0;
         x = 652032874;
         y = 0;
         if (a > QUARTER_TURN) begin
            a -= HALF_TURN; flip = 1;
         end else if (a < -QUARTER_TURN) begin
            a += HALF_TURN; flip = 1;
         end
         z = a * 32768;
         for (int i = 0; i < CORDIC_STEPS && i < ATAN_DEPTH; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(atan_entry(STEP_W'(i)));
            end else begin
               x += dx; y -= dy; z += longint'(atan_entry(STEP_W'(i)));
            end
         end
         if (flip) begin
            x = -x; y = -y;
         end
         c = q14(x);
         s = q14(y);
      endfunction

      function longint unsigned sqrt_floor(longint unsigned n);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= r + b) begin
               n -= r + b; r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
         end
         return r;
      endfunction

      function void unitise(longint v [3], output logic signed [15:0] o [3]);
         longint unsigned sq, len, mag, q;
         sq = 0;
         for (int i = 0; i < 3; i++) sq += longint'(v[i] * v[i]);
         len = sqrt_floor(sq);
         for (int i = 0; i < 3; i++) begin
            if (len == 0) o[i] = 0;
            else begin
               mag = v[i] < 0 ? -v[i] : v[i];
               q = (mag * UNIT + len / 2) / len;
               if (q > UNIT) q = UNIT;
               o[i] = 16'(v[i] < 0 ? -longint'(q) : longint'(q));
            end
         end
      endfunction

      function void crossp(logic signed [15:0] a [3], logic signed [15:0] b [3],
                           output longint c [3]);
         c[0] = longint'(a[1]) * b[2] - longint'(a[2]) * b[1];
         c[1] = longint'(a[2]) * b[0] - longint'(a[0]) * b[2];
         c[2] = longint'(a[0]) * b[1] - longint'(a[1]) * b[0];
      endfunction

      function void side_vecs();
         longint c [3];
         crossp(fv, wup, c);
         unitise(c, rv);
         crossp(rv, fv, c);
         unitise(c, uv);
      endfunction

      function void front_from_angles();
         longint sy, cy, sp, cp, f [3];
         sin_cos(yaw, sy, cy);
         sin_cos(pitch, sp, cp);
         f[0] = cy * cp;
         f[1] = sp * UNIT;
         f[2] = sy * cp;
         unitise(f, fv);
         side_vecs();
      endfunction

      function void note_request(req_type r);
         longint tp [3], td [3], spd, st, dyaw, dpit, p, sgn;
         logic signed [15:0] mv [3];
         bit moves;
         rsp_type e;
         tp = '{r.target_pos_x, r.target_pos_y, r.target_pos_z};
         td = '{r.target_dir_x, r.target_dir_y, r.target_dir_z};
         case (r.kind)
            KIND_MOVE: begin
               spd = longint'(speed) * longint'(r.delta_time);
               moves = 1;
               sgn = 1;
               case (r.move_dir)
                  DIR_FWD, DIR_BACK:  mv = fv;
                  DIR_LEFT, DIR_RIGHT: mv = rv;
                  DIR_UP, DIR_DOWN:   mv = wup;
                  default: moves = 0;
               endcase
               if (r.move_dir inside {DIR_BACK, DIR_LEFT, DIR_DOWN}) sgn = -1;
               if (moves)
                  for (int i = 0; i < 3; i++) begin
                     st = (longint'(mv[i]) * spd + (64'sd1 << 21)) >>> 22;
                     pos[i] = 32'(sat32(longint'(pos[i]) + sgn * st));
                  end
            end
            KIND_MOUSE: begin
               dyaw = (longint'(r.offset_x) * longint'(sens) + 4096) >>> 13;
               dpit = (longint'(r.offset_y) * longint'(sens) + 4096) >>> 13;
               p = longint'(pitch) + dpit;
               yaw = wrap_deg(longint'(yaw) + dyaw);
               if (r.clamp_pitch) begin
                  if (p > PITCH_LIMIT) p = PITCH_LIMIT;
                  if (p < -PITCH_LIMIT) p = -PITCH_LIMIT;
                  pitch = 16'(p);
               end else pitch = wrap_deg(p);
               front_from_angles();
            end
            KIND_THIRD: begin
               for (int i = 0; i < 3; i++) begin
                  pos[i] = 32'(sat32(tp[i] - td[i] * 32 + (i == 1 ? TP_LIFT : 0)));
                  fv[i] = 16'(td[i]);
               end
               pitch = 16'(TP_PITCH);
               side_vecs();
            end
            default: begin
               for (int i = 0; i < 3; i++)
                  pos[i] = 32'(sat32(tp[i] + ((td[i] * FP_SCALE + 8192) >>> 14)
                                     + (i == 1 ? FP_LIFT : 0)));
               front_from_angles();
            end
         endcase
         e = '{pos[0], pos[1], pos[2], fv[0], fv[1], fv[2],
               rv[0], rv[1], rv[2], uv[0], uv[1], uv[2]};
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $realtime, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (got.cam_pos_x !== e.cam_pos_x || got.cam_pos_y !== e.cam_pos_y ||
             got.cam_pos_z !== e.cam_pos_z || got.front_x !== e.front_x ||
             got.front_y !== e.front_y || got.front_z !== e.front_z ||
             got.right_x !== e.right_x || got.right_y !== e.right_y ||
             got.right_z !== e.right_z || got.up_x !== e.up_x ||
             got.up_y !== e.up_y || got.up_z !== e.up_z) begin
            $display("%0t: mismatch expected pos %0d %0d %0d f %0d %0d %0d r %0d %0d %0d u %0d %0d %0d",
                     $realtime, e.cam_pos_x, e.cam_pos_y, e.cam_pos_z, e.front_x, e.front_y,
                     e.front_z, e.right_x, e.right_y, e.right_z, e.up_x, e.up_y, e.up_z);
            $display("%0t:          actual   pos %0d %0d %0d f %0d %0d %0d r %0d %0d %0d u %0d %0d %0d",
                     $realtime, got.cam_pos_x, got.cam_pos_y, got.cam_pos_z, got.front_x,
                     got.front_y, got.front_z, got.right_x, got.right_y, got.right_z,
                     got.up_x, got.up_y, got.up_z);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
   req_type req_data = '0;
   rsp_type rsp_data;
   logic csr_wr_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int send_idle = 0, recv_idle = 0;
   int cycles = 0, sent = 0;
   camera_scoreboard camera_sb = new();

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   euler_fly_camera_update i_dut (.*);

   // receiver: random stall, check on every accepted response
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_valid && rsp_ready) camera_sb.check_response(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (cycles > 4000000) begin
         $display("** euler_fly_camera_update: FAILED **");
         $finish;
      end
   end

   // hold valid between back-to-back transactions; drop it only when idling
   task automatic send(req_type r);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      camera_sb.note_request(r);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (camera_sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      camera_sb.set_reg(idx, val);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   function automatic req_type rand_req();
      req_type r;
      r = $bits(req_type)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom});
      r.kind = 2'($urandom_range(3));
      if ($urandom_range(9) != 0) r.move_dir = 3'($urandom_range(5));
      if ($urandom_range(3) != 0) begin
         r.target_dir_x = 16'($signed($urandom_range(32768)) - 16384);
         r.target_dir_y = 16'($signed($urandom_range(32768)) - 16384);
         r.target_dir_z = 16'($signed($urandom_range(32768)) - 16384);
      end
      if ($urandom_range(3) != 0) begin
         r.offset_x = 16'($signed($urandom_range(4000)) - 2000);
         r.offset_y = 16'($signed($urandom_range(4000)) - 2000);
      end
      if ($urandom_range(3) != 0) begin
         r.target_pos_x = $signed($urandom_range(20000000)) - 10000000;
         r.target_pos_y = $signed($urandom_range(20000000)) - 10000000;
         r.target_pos_z = $signed($urandom_range(20000000)) - 10000000;
      end
      return r;
   endfunction

   task automatic random_phase(int n);
      repeat (n) send(rand_req());
   endtask

   initial begin
      req_type r;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: every kind, each direction, extremes
      for (int d = 0; d < 8; d++) begin
         r = '0;
         r.kind = KIND_MOVE; r.move_dir = 3'(d); r.delta_time = 16'hFFFF;
         send(r);
      end
      r = '0; r.kind = KIND_MOUSE; r.offset_x = 16'sh7FFF; r.offset_y = 16'sh7FFF;
      r.clamp_pitch = 1; send(r);
      r.offset_x = -16'sh8000; r.offset_y = -16'sh8000; r.clamp_pitch = 0; send(r);
      r.offset_y = 16'sh4000; send(r);
      r = '0; r.kind = KIND_THIRD; r.target_pos_x = 32'sh7FFFFFFF;
      r.target_pos_y = 32'sh7FFFFFFF; r.target_pos_z = -32'sh80000000;
      r.target_dir_x = -16'sd16384; r.target_dir_y = -16'sd16384; r.target_dir_z = 16'sd16384;
      send(r);
      r.target_dir_x = 0; r.target_dir_y = 16'sd16384; r.target_dir_z = 0; send(r);
      r.target_dir_y = 0; send(r);
      r = '0; r.kind = KIND_FIRST; r.target_pos_y = 32'sh7FFFFFFF;
      r.target_pos_x = -32'sh80000000; r.target_dir_y = 16'sd16384;
      r.target_dir_x = -16'sd16384; send(r);
      r = '0; r.kind = KIND_MOVE; r.move_dir = DIR_UP; r.delta_time = 16'hFFFF; send(r);
      r.move_dir = DIR_DOWN; send(r);
      drain();
      write_reg(CSR_SPEED, 16'hFFFF); write_reg(CSR_SENS, 16'hFFFF);
      write_reg(CSR_UP_X, 16'sd16384); write_reg(CSR_UP_Y, 0); write_reg(CSR_UP_Z, -16'sd16384);
      r = '0; r.kind = KIND_MOVE; r.move_dir = DIR_UP; r.delta_time = 16'hFFFF;
      repeat (3) send(r);
      r.kind = KIND_MOUSE; r.offset_x = 16'sh7FFF; send(r);
      send_idle = 34; recv_idle = 71;
      random_phase(130);
      drain();
      write_reg(CSR_SPEED, 0); write_reg(CSR_SENS, 0);
      write_reg(CSR_UP_X, -16'sd16384); write_reg(CSR_UP_Y, -16'sd16384);
      write_reg(CSR_UP_Z, 16'sd16384);
      send_idle = 71; recv_idle = 34;
      random_phase(130);
      drain();
      write_reg(CSR_SPEED, 640); write_reg(CSR_SENS, 6554);
      write_reg(CSR_UP_X, 0); write_reg(CSR_UP_Y, 16'sd16384); write_reg(CSR_UP_Z, 0);
      send_idle = 0; recv_idle = 0;
      random_phase(140);
      drain();
      $display("Sent %0d transactions of all kinds over four register settings; %0d responses checked.",
               sent, camera_sb.checked);
      if (camera_sb.errors == 0 && camera_sb.pending.size() == 0)
         $display("** euler_fly_camera_update: PASSED **");
      else
         $display("** euler_fly_camera_update: FAILED **");
      $finish;
   end
endmodule

// File: sim.f
+incdir+src
src/efc_pkg.sv
src/efc_cordic.sv
src/efc_norm.sv
src/euler_fly_camera_update.sv
dv/tb.sv
